// ===== design/stepper_ramp_pulse_generator_macros.svh =====
// assertion macros shared by the stepper ramp pulse generator modules
// no dependencies; included by the modules that carry assertions
`ifndef STEPPER_RAMP_PULSE_GENERATOR_MACROS_SVH
`define STEPPER_RAMP_PULSE_GENERATOR_MACROS_SVH

// same-cycle implication
`define SRPG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/srpg_pkg.sv =====
// shared types and constants of the stepper ramp pulse generator
// no dependencies; used by srpg_ctrl, srpg_dp and the top level
package srpg_pkg;

    localparam int DELAY_W   = 16;
    localparam int RAMP_W    = 15;
    localparam int STEPS_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int DIV_CNT_W = 4;

    localparam logic [DELAY_W-1:0] START_DELAY_RST  = 16'd500;
    localparam logic [DELAY_W-1:0] CRUISE_DELAY_RST = 16'd500;
    localparam logic [RAMP_W-1:0]  RAMP_LEN_RST     = 15'd50;
    localparam logic [DELAY_W-1:0] DELAY_MAX        = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_DELAY  = 2'd0,
        CFG_CRUISE_DELAY = 2'd1,
        CFG_RAMP_LENGTH  = 2'd2,
        CFG_RAMP_MODE    = 2'd3
    } t_cfg_idx;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture result of the accepted beat
        logic start;     // set up a new move
        logic tick;      // advance a running move by one tick
        logic div_step;  // one quotient bit of the increment division
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_div;  // ramped move with a nonzero delay difference to divide
        logic div_last;  // last quotient bit in this cycle
        logic move_end;  // the current tick ends the move
    } t_status;

endpackage

// ===== design/srpg_ctrl.sv =====
// control state machine of the stepper ramp pulse generator: handshakes and sequencing
// depends on srpg_pkg and stepper_ramp_pulse_generator_macros.svh
`include "stepper_ramp_pulse_generator_macros.svh"

module srpg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_cmd,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  srpg_pkg::t_status i_status,
    output srpg_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_RUN  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_fire;

    assign o_in_ready  = (r_state != ST_DIV) && (!r_out_valid || i_out_ready);
    assign w_fire      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.load     = w_fire;
        o_cmd.start    = w_fire && (r_state == ST_IDLE) && i_in_cmd;
        o_cmd.tick     = w_fire && (r_state == ST_RUN);
        o_cmd.div_step = (r_state == ST_DIV);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.start) begin
                    n_state = i_status.need_div ? ST_DIV : ST_RUN;
                end
            end
            ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (o_cmd.tick && i_status.move_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `SRPG_ASSERT_NOW(a_div_holds_input, i_clk, i_rst_n, r_state == ST_DIV, !o_in_ready, "input taken during division")
    `SRPG_ASSERT_NEXT(a_start_leaves_idle, i_clk, i_rst_n, o_cmd.start, r_state != ST_IDLE, "start did not begin a move")
    `SRPG_ASSERT_NEXT(a_beat_gives_result, i_clk, i_rst_n, w_fire, r_out_valid, "accepted beat produced no result")
    `SRPG_ASSERT_NEXT(a_div_finishes, i_clk, i_rst_n, (r_state == ST_DIV) && i_status.div_last, r_state == ST_RUN, "division did not hand over to run")

endmodule

// ===== design/srpg_dp.sv =====
// datapath of the stepper ramp pulse generator: config registers, step and tick
// counters, half period, increment divider and result register; depends on srpg_pkg
module srpg_dp #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [srpg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [srpg_pkg::CFG_W-1:0]         i_cfg_data,
    input  srpg_pkg::t_cmd                     i_cmd,
    input  logic [srpg_pkg::STEPS_W-1:0]       i_move_steps,
    input  logic                               i_direction,
    input  logic                               i_cw_limit_hit,
    input  logic                               i_ccw_limit_hit,
    output srpg_pkg::t_status                  o_status,
    output logic                               o_step_level,
    output logic                               o_enable_level,
    output logic                               o_dir_level,
    output logic                               o_busy_res,
    output logic                               o_move_done,
    output logic                               o_stopped_by_limit
);

    typedef logic [COUNT_WIDTH-1:0]             t_cnt;
    typedef logic [srpg_pkg::DELAY_W-1:0]       t_delay;
    typedef logic [srpg_pkg::STEPS_W-1:0]       t_steps;

    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2
    } t_phase;

    function automatic t_delay at_least_one(input t_delay v);
        at_least_one = (v == '0) ? t_delay'(1) : v;
    endfunction

    // config
    t_delay                        r_start_delay, r_cruise_delay;
    logic [srpg_pkg::RAMP_W-1:0]   r_ramp_len;
    logic                          r_ramp_mode;

    // move state
    t_phase r_phase, n_phase;
    t_cnt   r_left, n_left;
    t_cnt   r_cru, n_cru;
    t_cnt   r_dec, n_dec;
    t_cnt   r_tick, n_tick;
    t_delay r_hp, n_hp;
    t_delay r_inc, n_inc;
    logic   r_pulse, n_pulse;
    logic   r_dir, n_dir;

    // divider
    logic [srpg_pkg::RAMP_W-1:0]    r_rem, n_rem;
    logic [srpg_pkg::DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;

    // result
    logic r_o_step, r_o_busy, r_o_done, r_o_lim;
    logic n_o_step, n_o_busy, n_o_done, n_o_lim;

    logic                 w_need_div;
    t_steps               w_two_rl, w_acc, w_cru, w_dec;
    logic                 w_short;
    t_delay               w_trial, w_diff;
    logic                 w_ge;
    logic                 w_boundary, w_limit, w_no_step;
    t_phase               w_eff_phase;
    t_cnt                 w_eff_left;
    t_delay               w_hp_step;
    logic [srpg_pkg::DELAY_W:0] w_hp_sum;

    assign w_need_div = r_ramp_mode && (r_ramp_len != '0) && (r_cruise_delay < r_start_delay);

    // setup split of the move
    assign w_two_rl = {r_ramp_len, 1'b0};
    assign w_short  = i_move_steps < w_two_rl;
    always_comb begin
        if (r_ramp_mode) begin
            if (w_short) begin
                w_acc = i_move_steps >> 1;
                w_dec = i_move_steps - w_acc;
                w_cru = '0;
            end else begin
                w_acc = {1'b0, r_ramp_len};
                w_dec = {1'b0, r_ramp_len};
                w_cru = i_move_steps - w_two_rl;
            end
        end else begin
            w_acc = '0;
            w_dec = '0;
            w_cru = i_move_steps;
        end
    end

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_rem, r_inc[srpg_pkg::DELAY_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_ramp_len};
    assign w_diff  = w_trial - {1'b0, r_ramp_len};

    // step boundary with empty phases skipped
    assign w_boundary = (r_tick == '0) && !r_pulse;
    assign w_limit    = r_dir ? i_ccw_limit_hit : i_cw_limit_hit;
    always_comb begin
        w_eff_phase = r_phase;
        w_eff_left  = r_left;
        w_no_step   = 1'b0;
        case (r_phase)
            PH_ACCEL: begin
                if (r_left != '0) begin
                    w_eff_phase = PH_ACCEL;
                end else if (r_cru != '0) begin
                    w_eff_phase = PH_CRUISE;
                    w_eff_left  = r_cru;
                end else if (r_dec != '0) begin
                    w_eff_phase = PH_DECEL;
                    w_eff_left  = r_dec;
                end else begin
                    w_no_step = 1'b1;
                end
            end
            PH_CRUISE: begin
                if (r_left == '0) begin
                    if (r_dec != '0) begin
                        w_eff_phase = PH_DECEL;
                        w_eff_left  = r_dec;
                    end else begin
                        w_no_step = 1'b1;
                    end
                end
            end
            PH_DECEL: begin
                w_no_step = (r_left == '0);
            end
            default: w_no_step = 1'b1;
        endcase
    end

    assign w_hp_sum = {1'b0, r_hp} + {1'b0, r_inc};
    always_comb begin
        case (w_eff_phase)
            PH_ACCEL:  w_hp_step = (r_hp > r_inc) ? (r_hp - r_inc) : t_delay'(1);
            PH_DECEL:  w_hp_step = w_hp_sum[srpg_pkg::DELAY_W] ? srpg_pkg::DELAY_MAX
                                                               : w_hp_sum[srpg_pkg::DELAY_W-1:0];
            default:   w_hp_step = r_hp;
        endcase
    end

    always_comb begin
        o_status.need_div = w_need_div;
        o_status.div_last = (r_div_cnt == '1);
        o_status.move_end = w_boundary && (w_no_step || w_limit);
    end

    always_comb begin
        n_phase   = r_phase;
        n_left    = r_left;
        n_cru     = r_cru;
        n_dec     = r_dec;
        n_tick    = r_tick;
        n_hp      = r_hp;
        n_inc     = r_inc;
        n_pulse   = r_pulse;
        n_dir     = r_dir;
        n_rem     = r_rem;
        n_div_cnt = r_div_cnt;
        n_o_step  = 1'b0;
        n_o_busy  = 1'b0;
        n_o_done  = 1'b0;
        n_o_lim   = 1'b0;
        if (i_cmd.start) begin
            n_dir     = i_direction;
            n_phase   = PH_ACCEL;
            n_left    = t_cnt'(w_acc);
            n_cru     = t_cnt'(w_cru);
            n_dec     = t_cnt'(w_dec);
            n_hp      = at_least_one(r_ramp_mode ? r_start_delay : r_cruise_delay);
            n_inc     = w_need_div ? (r_start_delay - r_cruise_delay) : '0;
            n_rem     = '0;
            n_div_cnt = '0;
            n_tick    = '0;
            n_pulse   = 1'b0;
            n_o_busy  = 1'b1;
        end else if (i_cmd.div_step) begin
            n_rem     = w_ge ? w_diff[srpg_pkg::RAMP_W-1:0] : w_trial[srpg_pkg::RAMP_W-1:0];
            n_inc     = {r_inc[srpg_pkg::DELAY_W-2:0], w_ge};
            n_div_cnt = r_div_cnt + 1'b1;
        end else if (i_cmd.tick) begin
            if (r_tick != '0) begin
                n_tick   = r_tick - t_cnt'(1);
                n_o_step = r_pulse;
                n_o_busy = 1'b1;
            end else if (r_pulse) begin
                n_pulse  = 1'b0;
                n_tick   = t_cnt'(r_hp - t_delay'(1));
                n_o_busy = 1'b1;
            end else if (w_no_step || w_limit) begin
                n_left   = '0;
                n_tick   = '0;
                n_pulse  = 1'b0;
                n_o_done = 1'b1;
                n_o_lim  = !w_no_step;
            end else begin
                n_phase  = w_eff_phase;
                n_left   = w_eff_left - t_cnt'(1);
                n_hp     = w_hp_step;
                n_pulse  = 1'b1;
                n_tick   = t_cnt'(w_hp_step - t_delay'(1));
                n_o_step = 1'b1;
                n_o_busy = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delay  <= srpg_pkg::START_DELAY_RST;
            r_cruise_delay <= srpg_pkg::CRUISE_DELAY_RST;
            r_ramp_len     <= srpg_pkg::RAMP_LEN_RST;
            r_ramp_mode    <= 1'b0;
        end else if (i_cfg_we) begin
            case (srpg_pkg::t_cfg_idx'(i_cfg_idx))
                srpg_pkg::CFG_START_DELAY:  r_start_delay  <= i_cfg_data;
                srpg_pkg::CFG_CRUISE_DELAY: r_cruise_delay <= i_cfg_data;
                srpg_pkg::CFG_RAMP_LENGTH:  r_ramp_len     <= i_cfg_data[srpg_pkg::RAMP_W-1:0];
                srpg_pkg::CFG_RAMP_MODE:    r_ramp_mode    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_ACCEL;
            r_left    <= '0;
            r_cru     <= '0;
            r_dec     <= '0;
            r_tick    <= '0;
            r_hp      <= '0;
            r_inc     <= '0;
            r_pulse   <= 1'b0;
            r_dir     <= 1'b0;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else begin
            r_phase   <= n_phase;
            r_left    <= n_left;
            r_cru     <= n_cru;
            r_dec     <= n_dec;
            r_tick    <= n_tick;
            r_hp      <= n_hp;
            r_inc     <= n_inc;
            r_pulse   <= n_pulse;
            r_dir     <= n_dir;
            r_rem     <= n_rem;
            r_div_cnt <= n_div_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_step <= n_o_step;
            r_o_busy <= n_o_busy;
            r_o_done <= n_o_done;
            r_o_lim  <= n_o_lim;
        end
    end

    assign o_step_level       = r_o_step;
    assign o_enable_level     = r_o_busy;
    assign o_busy_res         = r_o_busy;
    assign o_dir_level        = r_dir;
    assign o_move_done        = r_o_done;
    assign o_stopped_by_limit = r_o_lim;

endmodule

// ===== design/stepper_ramp_pulse_generator.sv =====
// top level of the stepper ramp pulse generator: stream ports and config port
// depends on srpg_pkg, srpg_ctrl and srpg_dp
//
// Each input beat is one time tick or a start command and yields one result beat
// through a single output register, so one beat per cycle is taken while the
// result side keeps up. A ramped start with start_delay above cruise_delay and a
// nonzero ramp length is followed by a division in which no beat is taken: the
// per-step delay increment is worked out by a restoring divider, one quotient bit
// per cycle. Step pulses are high for the current half period in ticks and low for
// as many; the direction output holds the last move's direction.
module stepper_ramp_pulse_generator #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [srpg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [srpg_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,  // move_steps[15:0], direction,
                                                          // cw_limit_hit, ccw_limit_hit
    input  logic                           s_axis_tuser,  // cmd
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,  // step_level, enable_level,
                                                          // dir_level, busy_res,
                                                          // stopped_by_limit
    output logic                           m_axis_tlast   // move_done
);

    srpg_pkg::t_cmd    w_cmd;
    srpg_pkg::t_status w_status;
    logic w_step, w_en, w_dir, w_busy, w_lim;

    srpg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_cmd    (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    srpg_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_cmd              (w_cmd),
        .i_move_steps       (s_axis_tdata[15:0]),
        .i_direction        (s_axis_tdata[16]),
        .i_cw_limit_hit     (s_axis_tdata[17]),
        .i_ccw_limit_hit    (s_axis_tdata[18]),
        .o_status           (w_status),
        .o_step_level       (w_step),
        .o_enable_level     (w_en),
        .o_dir_level        (w_dir),
        .o_busy_res         (w_busy),
        .o_move_done        (m_axis_tlast),
        .o_stopped_by_limit (w_lim)
    );

    assign m_axis_tdata = {3'b000, w_lim, w_busy, w_dir, w_en, w_step};

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench for stepper_ramp_pulse_generator: directed table, then phases of random items
// checks each result beat against a typed row or the motion predictor; needs srpg_pkg, rtl
module testbench;
    import srpg_pkg::*;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_COUNT = 14;
    localparam int PHASE_ITEMS = 50;

    typedef enum logic [1:0] {MV_IDLE, MV_ACCEL, MV_CRUISE, MV_DECEL} move_phase_t;

    typedef struct packed {
        logic [DELAY_W-1:0] start_delay;
        logic [DELAY_W-1:0] cruise_delay;
        logic [RAMP_W-1:0]  ramp_length;
        logic               ramp_mode;
    } motor_setting_t;

    typedef struct packed {
        logic               cmd;
        logic [STEPS_W-1:0] move_steps;
        logic               direction;
        logic               cw_hit;
        logic               ccw_hit;
    } motion_item_t;

    typedef struct packed {
        logic step_level;
        logic enable_level;
        logic dir_level;
        logic busy_res;
        logic move_done;
        logic stopped_by_limit;
    } pin_levels_t;

    typedef struct packed {
        logic [1:0]   setting;
        motion_item_t item;
        logic         typed;
        pin_levels_t  pins;
    } stim_row_t;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_START_DELAY;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;  // move_steps[15:0], direction, cw_limit_hit,
                                              // ccw_limit_hit
    logic                 s_axis_tuser = 1'b0;  // cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;  // step_level, enable_level, dir_level, busy_res,
                                         // stopped_by_limit
    logic                 m_axis_tlast;  // move_done

    stepper_ramp_pulse_generator #(
        .COUNT_WIDTH(16)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predictor state
    motor_setting_t active_setting;
    move_phase_t    mv_phase = MV_IDLE;
    logic           mv_dir = 1'b0;
    int unsigned    mv_steps_left = 0;
    int unsigned    mv_cruise_steps = 0;
    int unsigned    mv_decel_steps = 0;
    int unsigned    mv_half_period = 0;
    int unsigned    mv_delay_inc = 0;
    int unsigned    mv_ticks_left = 0;
    logic           mv_pulse_high = 1'b0;

    pin_levels_t pin_levels_q[$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          limit_odds = 8;
    bit          hold_off_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic pin_levels_t advance_move(input motion_item_t it);
        pin_levels_t p;
        int unsigned steps, rl, acc, cru, dec;
        int          guard;
        p = '0;
        steps = 32'(it.move_steps);
        rl = 32'(active_setting.ramp_length);
        if (mv_phase == MV_IDLE) begin
            if (it.cmd == CMD_START) begin
                mv_dir = it.direction;
                if (active_setting.ramp_mode) begin
                    if (steps < 2 * rl) begin
                        acc = steps / 2;
                        dec = steps - acc;
                        cru = 0;
                    end else begin
                        acc = rl;
                        dec = rl;
                        cru = steps - 2 * rl;
                    end
                    if (rl == 0 || active_setting.cruise_delay >= active_setting.start_delay)
                        mv_delay_inc = 0;
                    else
                        mv_delay_inc = (32'(active_setting.start_delay)
                                        - 32'(active_setting.cruise_delay)) / rl;
                    mv_half_period = 32'(active_setting.start_delay);
                end else begin
                    acc = 0;
                    cru = steps;
                    dec = 0;
                    mv_delay_inc = 0;
                    mv_half_period = 32'(active_setting.cruise_delay);
                end
                if (mv_half_period == 0) mv_half_period = 1;
                mv_phase = MV_ACCEL;
                mv_steps_left = acc;
                mv_cruise_steps = cru;
                mv_decel_steps = dec;
                mv_ticks_left = 0;
                mv_pulse_high = 1'b0;
                p.enable_level = 1'b1;
                p.busy_res = 1'b1;
            end
        end else if (mv_ticks_left != 0) begin
            mv_ticks_left = mv_ticks_left - 1;
            p.step_level = mv_pulse_high;
            p.enable_level = 1'b1;
            p.busy_res = 1'b1;
        end else if (mv_pulse_high) begin
            mv_pulse_high = 1'b0;
            mv_ticks_left = mv_half_period - 1;
            p.enable_level = 1'b1;
            p.busy_res = 1'b1;
        end else begin
            // step boundary: skip empty phases first
            for (guard = 0; guard < 3 && mv_steps_left == 0 && mv_phase != MV_IDLE; guard++) begin
                case (mv_phase)
                    MV_ACCEL: begin
                        mv_phase = MV_CRUISE;
                        mv_steps_left = mv_cruise_steps;
                    end
                    MV_CRUISE: begin
                        mv_phase = MV_DECEL;
                        mv_steps_left = mv_decel_steps;
                    end
                    default: mv_phase = MV_IDLE;
                endcase
            end
            if (mv_phase == MV_IDLE || mv_steps_left == 0) begin
                mv_phase = MV_IDLE;
                p.move_done = 1'b1;
            end else if (mv_dir ? it.ccw_hit : it.cw_hit) begin
                mv_phase = MV_IDLE;
                p.move_done = 1'b1;
                p.stopped_by_limit = 1'b1;
            end else begin
                mv_steps_left = mv_steps_left - 1;
                if (mv_phase == MV_ACCEL) begin
                    mv_half_period = (mv_half_period > mv_delay_inc)
                                     ? mv_half_period - mv_delay_inc : 1;
                end else if (mv_phase == MV_DECEL) begin
                    mv_half_period = mv_half_period + mv_delay_inc;
                    if (mv_half_period > 32'(DELAY_MAX)) mv_half_period = 32'(DELAY_MAX);
                end
                if (mv_half_period == 0) mv_half_period = 1;
                mv_pulse_high = 1'b1;
                mv_ticks_left = mv_half_period - 1;
                p.step_level = 1'b1;
                p.enable_level = 1'b1;
                p.busy_res = 1'b1;
            end
            if (mv_phase == MV_IDLE) begin
                mv_steps_left = 0;
                mv_ticks_left = 0;
                mv_pulse_high = 1'b0;
            end
        end
        p.dir_level = mv_dir;
        return p;
    endfunction

    function automatic stim_row_t stim_row(input logic [1:0] sel, input logic cmd,
                                           input logic [15:0] steps, input logic dir,
                                           input logic cw, input logic ccw,
                                           input logic typed, input logic [5:0] pins);
        stim_row_t r;
        r.setting = sel;
        r.item = {cmd, steps, dir, cw, ccw};
        r.typed = typed;
        r.pins = pins;
        return r;
    endfunction

    function automatic motion_item_t random_item();
        motion_item_t it;
        it.cmd = CMD_TICK;
        it.move_steps = 16'($urandom);
        it.direction = 1'($urandom);
        if (mv_phase == MV_IDLE) begin
            if ($urandom_range(3) != 0) it.cmd = CMD_START;
            if ($urandom_range(99) < 85) it.move_steps = 16'($urandom_range(12));
            it.cw_hit = 1'($urandom);
            it.ccw_hit = 1'($urandom);
        end else begin
            if ($urandom_range(9) == 0) it.cmd = CMD_START;
            it.cw_hit = ($urandom_range(limit_odds - 1) == 0);
            it.ccw_hit = ($urandom_range(limit_odds - 1) == 0);
        end
        return it;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic offer_item(input motion_item_t it, input logic typed, input pin_levels_t pins);
        pin_levels_t predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.cmd;
        s_axis_tdata <= {5'd0, it.ccw_hit, it.cw_hit, it.direction, it.move_steps};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = advance_move(it);
        pin_levels_q.push_back(typed ? pins : predicted);
        @(negedge i_clk);
    endtask

    // end any running move, let the block go quiet, then load all four registers
    task automatic apply_setting(input motor_setting_t s);
        while (mv_phase != MV_IDLE)
            offer_item({CMD_TICK, 16'd0, 1'b0, 1'b1, 1'b1}, 1'b0, '0);
        s_axis_tvalid <= 1'b0;
        while (pin_levels_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_START_DELAY;
        i_cfg_data <= s.start_delay;
        @(negedge i_clk);
        i_cfg_idx <= CFG_CRUISE_DELAY;
        i_cfg_data <= s.cruise_delay;
        @(negedge i_clk);
        i_cfg_idx <= CFG_RAMP_LENGTH;
        i_cfg_data <= {1'b0, s.ramp_length};
        @(negedge i_clk);
        i_cfg_idx <= CFG_RAMP_MODE;
        i_cfg_data <= {15'd0, s.ramp_mode};
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        active_setting = s;
    endtask

    task automatic check_pins(input pin_levels_t exp_p, input pin_levels_t got);
        if (got.step_level !== exp_p.step_level) begin
            $error("step_level: expected %0b, got %0b", exp_p.step_level, got.step_level);
            mismatch_count++;
        end
        if (got.enable_level !== exp_p.enable_level) begin
            $error("enable_level: expected %0b, got %0b", exp_p.enable_level, got.enable_level);
            mismatch_count++;
        end
        if (got.dir_level !== exp_p.dir_level) begin
            $error("dir_level: expected %0b, got %0b", exp_p.dir_level, got.dir_level);
            mismatch_count++;
        end
        if (got.busy_res !== exp_p.busy_res) begin
            $error("busy_res: expected %0b, got %0b", exp_p.busy_res, got.busy_res);
            mismatch_count++;
        end
        if (got.move_done !== exp_p.move_done) begin
            $error("move_done: expected %0b, got %0b", exp_p.move_done, got.move_done);
            mismatch_count++;
        end
        if (got.stopped_by_limit !== exp_p.stopped_by_limit) begin
            $error("stopped_by_limit: expected %0b, got %0b",
                   exp_p.stopped_by_limit, got.stopped_by_limit);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        pin_levels_t got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[2], m_axis_tdata[3],
                   m_axis_tlast, m_axis_tdata[4]};
            if (pin_levels_q.size() == 0) begin
                $error("result beat with nothing expected: %b", got);
                mismatch_count++;
            end else begin
                check_pins(pin_levels_q.pop_front(), got);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side ready, with one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin : stimulus
        stim_row_t      rows[0:25];
        motor_setting_t directed_settings[0:3];
        motor_setting_t phase_settings[0:7];
        int             phase_odds[0:7];
        motor_setting_t s;
        logic [1:0]     directed_sel;
        int             ph;
        int             n;

        active_setting = {START_DELAY_RST, CRUISE_DELAY_RST, RAMP_LEN_RST, 1'b0};
        directed_settings[0] = active_setting;
        directed_settings[1] = {16'd2, 16'd1, 15'd1, 1'b1};
        directed_settings[2] = {16'd5, 16'd0, 15'd1, 1'b1};
        directed_settings[3] = {16'd0, 16'd0, 15'd0, 1'b1};

        // reset settings: idle tick, limit stop, zero-step move
        rows[0]  = stim_row(2'd0, CMD_TICK,  16'd0,    1'b0, 1'b1, 1'b1, 1'b1, 6'b000000);
        rows[1]  = stim_row(2'd0, CMD_START, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 6'b011100);
        rows[2]  = stim_row(2'd0, CMD_TICK,  16'd0,    1'b0, 1'b1, 1'b1, 1'b1, 6'b001011);
        rows[3]  = stim_row(2'd0, CMD_TICK,  16'd0,    1'b0, 1'b0, 1'b0, 1'b1, 6'b001000);
        rows[4]  = stim_row(2'd0, CMD_START, 16'd0,    1'b0, 1'b0, 1'b0, 1'b1, 6'b010100);
        rows[5]  = stim_row(2'd0, CMD_TICK,  16'd0,    1'b0, 1'b0, 1'b0, 1'b1, 6'b000010);
        // short ramp with a start while busy, then a cw limit stop
        rows[6]  = stim_row(2'd1, CMD_START, 16'd2,    1'b1, 1'b1, 1'b0, 1'b1, 6'b011100);
        rows[7]  = stim_row(2'd1, CMD_TICK,  16'd0,    1'b0, 1'b1, 1'b0, 1'b0, '0);
        rows[8]  = stim_row(2'd1, CMD_START, 16'd9,    1'b0, 1'b0, 1'b0, 1'b0, '0);
        rows[9]  = stim_row(2'd1, CMD_TICK,  16'd0,    1'b0, 1'b0, 1'b0, 1'b0, '0);
        rows[10] = stim_row(2'd1, CMD_TICK,  16'd0,    1'b0, 1'b0, 1'b0, 1'b0, '0);
        rows[11] = stim_row(2'd1, CMD_TICK,  16'd0,    1'b0, 1'b0, 1'b0, 1'b0, '0);
        rows[12] = stim_row(2'd1, CMD_TICK,  16'd0,    1'b0, 1'b0, 1'b0, 1'b0, '0);
        rows[13] = stim_row(2'd1, CMD_TICK,  16'd0,    1'b0, 1'b0, 1'b0, 1'b1, 6'b001010);
        rows[14] = stim_row(2'd1, CMD_START, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b1, 6'b010100);
        rows[15] = stim_row(2'd1, CMD_TICK,  16'd0,    1'b0, 1'b0, 1'b1, 1'b0, '0);
        rows[16] = stim_row(2'd1, CMD_TICK,  16'd0,    1'b0, 1'b0, 1'b0, 1'b0, '0);
        rows[17] = stim_row(2'd1, CMD_TICK,  16'd0,    1'b0, 1'b1, 1'b0, 1'b1, 6'b000011);
        // increment equal to the half period: floor at one tick
        rows[18] = stim_row(2'd2, CMD_START, 16'd2,    1'b1, 1'b0, 1'b0, 1'b1, 6'b011100);
        rows[19] = stim_row(2'd2, CMD_TICK,  16'd0,    1'b0, 1'b0, 1'b0, 1'b0, '0);
        rows[20] = stim_row(2'd2, CMD_TICK,  16'd0,    1'b0, 1'b0, 1'b0, 1'b0, '0);
        rows[21] = stim_row(2'd2, CMD_TICK,  16'd0,    1'b0, 1'b0, 1'b0, 1'b0, '0);
        // zero delays and zero ramp length
        rows[22] = stim_row(2'd3, CMD_START, 16'd1,    1'b0, 1'b0, 1'b0, 1'b1, 6'b010100);
        rows[23] = stim_row(2'd3, CMD_TICK,  16'd0,    1'b0, 1'b0, 1'b0, 1'b0, '0);
        rows[24] = stim_row(2'd3, CMD_TICK,  16'd0,    1'b0, 1'b0, 1'b0, 1'b0, '0);
        rows[25] = stim_row(2'd3, CMD_TICK,  16'd0,    1'b0, 1'b0, 1'b0, 1'b1, 6'b000010);

        phase_settings[0] = {16'd500,   16'd500,   15'd50,    1'b0};
        phase_settings[1] = {16'd6,     16'd2,     15'd3,     1'b1};
        phase_settings[2] = {16'd3,     16'd3,     15'd0,     1'b1};
        phase_settings[3] = {16'd2,     16'd5,     15'd4,     1'b1};
        phase_settings[4] = {16'd5,     16'd0,     15'd1,     1'b1};
        phase_settings[5] = {16'd0,     16'd1,     15'd1,     1'b1};
        phase_settings[6] = {16'hFFFF,  16'd1,     15'h7FFF,  1'b1};
        phase_settings[7] = {16'hFFFF,  16'hFFFF,  15'h7FFF,  1'b0};
        phase_odds = '{1, 8, 8, 8, 8, 8, 1, 1};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_sel = 2'd0;
        for (n = 0; n < 26; n++) begin
            if (rows[n].setting != directed_sel) begin
                directed_sel = rows[n].setting;
                apply_setting(directed_settings[directed_sel]);
            end
            offer_item(rows[n].item, rows[n].typed, rows[n].pins);
        end

        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            if (ph < 8) begin
                s = phase_settings[ph];
                limit_odds = phase_odds[ph];
            end else if ($urandom_range(3) == 0) begin
                // wide random setting: moves are cut at their first step boundary
                s = {16'($urandom), 16'($urandom), 15'($urandom), 1'($urandom)};
                limit_odds = 1;
            end else begin
                s = {16'($urandom_range(12)), 16'($urandom_range(12)),
                     15'($urandom_range(6)), 1'($urandom_range(1))};
                limit_odds = 8;
            end
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 69; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 69; end
                default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
            endcase
            apply_setting(s);
            if (ph == 2) hold_off_req = 1'b1;
            repeat (PHASE_ITEMS) offer_item(random_item(), 1'b0, '0);
        end

        s_axis_tvalid <= 1'b0;
        while (pin_levels_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/srpg_pkg.sv
design/srpg_ctrl.sv
design/srpg_dp.sv
design/stepper_ramp_pulse_generator.sv
tb/testbench.sv
